// File: hdl/assert_macros.svh
// Assertion macros shared by the pulse-distance transmitter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define PDWT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define PDWT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/pdwt_pkg.sv
// Types and constants of the pulse-distance word transmitter.
`timescale 1ns / 1ps

package pdwt_pkg;

  typedef logic [15:0] tick_t;
  typedef logic [15:0] word_t;
  typedef logic [2:0]  reg_idx_t;

  // Input action codes.
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  // Configuration register indexes.
  localparam int       NUM_REGS         = 7;
  localparam reg_idx_t REG_LEAD_HIGH    = 3'd0;
  localparam reg_idx_t REG_HEADER_LOW   = 3'd1;
  localparam reg_idx_t REG_HEADER_HIGH  = 3'd2;
  localparam reg_idx_t REG_GAP_LOW      = 3'd3;
  localparam reg_idx_t REG_ZERO_HIGH    = 3'd4;
  localparam reg_idx_t REG_ONE_HIGH     = 3'd5;
  localparam reg_idx_t REG_STOP_HIGH    = 3'd6;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam tick_t CFG_RESET [NUM_REGS] = '{
    16'd5, 16'd20, 16'd14, 16'd5, 16'd15, 16'd35, 16'd35
  };

  // Fixed frame periods; the bit periods follow PH_BITS.
  localparam int PH_IDLE   = 0;
  localparam int PH_LEAD   = 1;
  localparam int PH_HDR_LO = 2;
  localparam int PH_HDR_HI = 3;
  localparam int PH_BITS   = 4;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic load_refused;
  } result_t;

endpackage

// File: hdl/pdwt_ifs.sv
// Request and result channel interfaces of the pulse-distance transmitter.
`timescale 1ns / 1ps

interface pdwt_in_if import pdwt_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  action;
  word_t word;

  modport source (output valid, output action, output word, input ready);
  modport sink   (input valid, input action, input word, output ready);
endinterface

interface pdwt_out_if import pdwt_pkg::*; ();
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic load_refused;

  modport source (output valid, output line_level, output busy_res,
                  output load_refused, input ready);
  modport sink   (input valid, input line_level, input busy_res,
                  input load_refused, output ready);
endinterface

// File: hdl/pulse_distance_word_transmitter.sv
// Pulse-distance word transmitter: frame sequencer, period registers, result register.
//
//   channel  | dir | handshake        | payload
//   ---------+-----+------------------+-----------------------------------------
//   in_ch    | in  | valid / ready    | action (tick or load), word
//   out_ch   | out | valid / ready    | line_level, busy_res, load_refused
//   APB      | in  | psel/penable     | paddr, pwdata, prdata (period registers)
//
// Each request is taken when valid and ready meet, and its result sits in the output register
// the next cycle; the counter decrement and period selection fit between them.
// A new request is taken every cycle while the result register is empty or drained.
// rst_n is synchronous and active low; it restores the reset periods and idles the line.
// A stalled result holds the result register and blocks new requests only then.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pulse_distance_word_transmitter
  import pdwt_pkg::*;
#(
  parameter int WORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pdwt_in_if.sink               in_ch,
  pdwt_out_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int PH_STOP_LO = PH_BITS + 2 * WORD_BITS;
  localparam int PH_STOP_HI = PH_STOP_LO + 1;
  localparam int PHASE_W    = $clog2(PH_STOP_HI + 1);

  typedef logic [PHASE_W-1:0]   phase_t;
  typedef logic [WORD_BITS-1:0] shift_t;

  // Period registers.
  tick_t    cfg_r [NUM_REGS];
  reg_idx_t cfg_idx;
  logic     cfg_wr;

  // Frame state.
  phase_t  phase_r,     phase_nxt;
  tick_t   remaining_r, remaining_nxt;
  shift_t  shifter_r,   shifter_nxt;
  logic    level_r,     level_nxt;
  logic    active_r,    active_nxt;

  // Result register.
  logic    out_valid_r, out_valid_nxt;
  result_t res_r,       res_nxt;

  logic    in_acc;
  logic    tick_last;
  logic    do_enter;
  phase_t  ent_phase;
  shift_t  ent_src;
  shift_t  word_ext;
  logic    refused;

  // ---------------------------------------------------------------- APB
  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && (int'(cfg_idx) < NUM_REGS);

  always_comb begin
    prdata = '0;
    if (int'(cfg_idx) < NUM_REGS) begin
      prdata = CFG_DATA_W'(cfg_r[cfg_idx]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_r[i] <= CFG_RESET[i];
      end
    end else if (cfg_wr) begin
      cfg_r[cfg_idx] <= pwdata[15:0];
    end
  end

  // ---------------------------------------------------------------- handshake
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign word_ext  = WORD_BITS'(in_ch.word);
  // A count of zero or one both end the period on this tick.
  assign tick_last = (remaining_r[15:1] == '0);

  // Decide whether this request enters a new period, and which one.
  always_comb begin
    do_enter  = 1'b0;
    ent_phase = phase_t'(PH_IDLE);
    ent_src   = shifter_r;
    refused   = 1'b0;
    if (in_ch.action == ACT_LOAD) begin
      if (active_r) begin
        refused = 1'b1;
      end else begin
        do_enter  = 1'b1;
        ent_phase = phase_t'(PH_LEAD);
        ent_src   = word_ext;
      end
    end else if (active_r && tick_last) begin
      do_enter = 1'b1;
      if (phase_r == phase_t'(PH_STOP_HI)) begin
        ent_phase = phase_t'(PH_IDLE);
      end else begin
        ent_phase = phase_r + 1'b1;
      end
    end
  end

  // Next frame state.
  always_comb begin
    phase_nxt     = phase_r;
    remaining_nxt = remaining_r;
    shifter_nxt   = shifter_r;
    level_nxt     = level_r;
    active_nxt    = active_r;
    if (do_enter) begin
      phase_nxt   = ent_phase;
      shifter_nxt = ent_src;
      active_nxt  = 1'b1;
      if (ent_phase == phase_t'(PH_LEAD)) begin
        level_nxt     = 1'b1;
        remaining_nxt = cfg_r[REG_LEAD_HIGH];
      end else if (ent_phase == phase_t'(PH_HDR_LO)) begin
        level_nxt     = 1'b0;
        remaining_nxt = cfg_r[REG_HEADER_LOW];
      end else if (ent_phase == phase_t'(PH_HDR_HI)) begin
        level_nxt     = 1'b1;
        remaining_nxt = cfg_r[REG_HEADER_HIGH];
      end else if (ent_phase == phase_t'(PH_STOP_HI)) begin
        level_nxt     = 1'b1;
        remaining_nxt = cfg_r[REG_STOP_HIGH];
      end else if (ent_phase >= phase_t'(PH_BITS) && ent_phase <= phase_t'(PH_STOP_LO)) begin
        // Bit periods alternate: even codes are the low gap, odd codes the bit high.
        if (!ent_phase[0]) begin
          level_nxt     = 1'b0;
          remaining_nxt = cfg_r[REG_GAP_LOW];
        end else begin
          level_nxt     = 1'b1;
          remaining_nxt = ent_src[WORD_BITS-1] ? cfg_r[REG_ONE_HIGH] : cfg_r[REG_ZERO_HIGH];
          shifter_nxt   = ent_src << 1;
        end
      end else begin
        phase_nxt     = phase_t'(PH_IDLE);
        level_nxt     = 1'b1;
        remaining_nxt = '0;
        active_nxt    = 1'b0;
      end
    end else if (in_ch.action == ACT_TICK && active_r) begin
      remaining_nxt = remaining_r - 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    if (in_acc) begin
      out_valid_nxt        = 1'b1;
      res_nxt.line_level   = level_nxt;
      res_nxt.busy_res     = active_nxt;
      res_nxt.load_refused = refused;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= phase_t'(PH_IDLE);
      remaining_r <= '0;
      shifter_r   <= '0;
      level_r     <= 1'b1;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        phase_r     <= phase_nxt;
        remaining_r <= remaining_nxt;
        shifter_r   <= shifter_nxt;
        level_r     <= level_nxt;
        active_r    <= active_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.line_level   = res_r.line_level;
  assign out_ch.busy_res     = res_r.busy_res;
  assign out_ch.load_refused = res_r.load_refused;

  // ---------------------------------------------------------------- checks
  `PDWT_ASSERT(a_idle_line_high, !active_r |-> (level_r && phase_r == phase_t'(PH_IDLE)), "idle line not high or phase not idle")
  `PDWT_ASSERT(a_refused_keeps_frame, (in_acc && in_ch.action == ACT_LOAD && active_r) |=> (active_r && $stable(phase_r) && $stable(remaining_r)), "refused load disturbed the running frame")
  `PDWT_ASSERT(a_request_gives_result, in_acc |=> (out_valid_r && res_r.busy_res == active_r && res_r.line_level == level_r), "result register does not match the state after a request")
  `PDWT_ASSERT(a_refused_only_busy, (in_acc && refused) |-> (active_r && in_ch.action == ACT_LOAD), "load flagged as refused while idle")
  `PDWT_ASSERT(a_phase_in_range, phase_r <= phase_t'(PH_STOP_HI), "phase beyond the stop period")
  `PDWT_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")

endmodule
